// ----- src/weekly_schedule_rule_evaluator_unit_assert.svh -----
// assertion macros used by the checker module of the schedule evaluator
`ifndef WEEKLY_SCHEDULE_RULE_EVALUATOR_UNIT_ASSERT_SVH
`define WEEKLY_SCHEDULE_RULE_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WSRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define WSRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/wsre_pkg.sv -----
package wsre_pkg;

  // default table depth
  localparam int MAX_RULES_DEF = 8;

  // field widths
  localparam int IDX_W     = 3;
  localparam int WDAY_W    = 7;
  localparam int MIN_W     = 11;
  localparam int NINT_W    = 8;
  localparam int WD_W      = 3;
  localparam int YEAR_W    = 12;
  localparam int RCNT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int DIV_W     = 16;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR   = 2'd1;

  // reset value of the year threshold and length of a day
  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd2020;
  localparam logic [DIV_W-1:0]  DAY_MINUTES  = 16'd1440;

  // one table entry
  typedef struct packed {
    logic              enabled;
    logic [WDAY_W-1:0] weekdays;
    logic [MIN_W-1:0]  start_min;
    logic [MIN_W-1:0]  end_min;
    logic              interval_mode;
    logic [NINT_W-1:0] intervals;
    logic [MIN_W-1:0]  duration;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_DIV_LEN,
    ST_DIV_POS,
    ST_DONE
  } state_e;

endpackage

// ----- src/wsre_if.sv -----
// input item channel
interface wsre_req_if import wsre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  rule_index;
  logic              rule_enabled;
  logic [WDAY_W-1:0] rule_weekdays;
  logic [MIN_W-1:0]  rule_start;
  logic [MIN_W-1:0]  rule_end;
  logic              rule_interval_mode;
  logic [NINT_W-1:0] rule_intervals;
  logic [MIN_W-1:0]  rule_duration;
  logic [WD_W-1:0]   weekday;
  logic [MIN_W-1:0]  minute_of_day;
  logic [YEAR_W-1:0] year;

  modport source (
    output valid, command, rule_index, rule_enabled, rule_weekdays, rule_start,
           rule_end, rule_interval_mode, rule_intervals, rule_duration, weekday,
           minute_of_day, year,
    input  ready
  );
  modport sink (
    input  valid, command, rule_index, rule_enabled, rule_weekdays, rule_start,
           rule_end, rule_interval_mode, rule_intervals, rule_duration, weekday,
           minute_of_day, year,
    output ready
  );
endinterface

// result channel
interface wsre_rsp_if ();
  logic valid;
  logic ready;
  logic active;
  logic clock_valid;

  modport source (output valid, active, clock_valid, input ready);
  modport sink (input valid, active, clock_valid, output ready);
endinterface

// configuration write channel
interface wsre_cfg_if import wsre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

// ----- src/wsre_ram.sv -----
module wsre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/wsre_div.sv -----
module wsre_div import wsre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_sts_t         sts_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  // one quotient bit per step, restoring
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ~trial[DIV_W]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quo_q;
  assign rem_o      = rem_q;

endmodule

// ----- src/weekly_schedule_rule_evaluator_unit.sv -----
// channel  modport  direction  moves
// req_i    sink     in         rule write or time evaluate request
// rsp_o    source   out        active and clock_valid, one per evaluate
// cfg_i    sink     in         register write: rule_count, min_valid_year
//
// a rule write is stored when taken; an evaluate fetches and checks each rule in turn, and
// for an interval rule the divider computes the slice length and then the position in the
// slice, stopping at the first matching rule
// the single bit-serial divider computes one quotient bit per cycle
// reset clears the rule valid bits and loads the registers; no clearing pass
// a result waiting in the output register holds the next evaluate only at its end
module weekly_schedule_rule_evaluator_unit import wsre_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsre_req_if.sink   req_i,
  wsre_rsp_if.source rsp_o,
  wsre_cfg_if.sink   cfg_i
);

  localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W  = $clog2(MAX_RULES + 1);

  state_e state_q, state_d;

  logic [RCNT_W-1:0] rule_cnt_q;
  logic [YEAR_W-1:0] min_year_q;
  logic [MAX_RULES-1:0] vld_q;
  logic              vld_rd_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  lim;
  logic              res_act_q, res_act_d;
  logic              res_cv_q, res_cv_d;
  logic [WD_W-1:0]   wd_q;
  logic [MIN_W-1:0]  min_q;
  logic              rsp_vld_q;
  logic              rsp_act_q;
  logic              rsp_cv_q;
  logic              rsp_load;

  logic              req_acc;
  logic              wr_acc;
  logic              wr_in_range;
  logic [ADDR_W-1:0] waddr;
  rule_t             wr_rule;
  rule_t             rule;
  logic              ram_re;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  div_sts_t          div_sts;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  div_rem;

  logic              in_win;
  logic              day_ok;
  logic              pre_match;
  logic [DIV_W-1:0]  win_len;
  logic [DIV_W-1:0]  min_ext;
  logic [DIV_W-1:0]  start_ext;
  logic [DIV_W-1:0]  end_ext;
  logic [DIV_W-1:0]  slice_pos;

  // handshake decode
  assign req_acc     = req_i.valid && req_i.ready;
  assign wr_acc      = req_acc && (req_i.command == CMD_WRITE);
  assign wr_in_range = 32'(req_i.rule_index) < 32'(MAX_RULES);
  assign waddr       = ADDR_W'(req_i.rule_index);

  assign wr_rule.enabled       = req_i.rule_enabled;
  assign wr_rule.weekdays      = req_i.rule_weekdays;
  assign wr_rule.start_min     = req_i.rule_start;
  assign wr_rule.end_min       = req_i.rule_end;
  assign wr_rule.interval_mode = req_i.rule_interval_mode;
  assign wr_rule.intervals     = req_i.rule_intervals;
  assign wr_rule.duration      = req_i.rule_duration;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_cnt_q <= '0;
      min_year_q <= MIN_YEAR_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_idx == REG_RULE_COUNT) begin
        rule_cnt_q <= cfg_i.wdata[RCNT_W-1:0];
      end else if (cfg_i.reg_idx == REG_MIN_YEAR) begin
        min_year_q <= cfg_i.wdata[YEAR_W-1:0];
      end
    end
  end

  // number of rules walked
  assign lim = (32'(rule_cnt_q) > 32'(MAX_RULES)) ? CNT_W'(MAX_RULES) : CNT_W'(rule_cnt_q);
  assign cnt_nxt = cnt_q + CNT_W'(1);

  // rule table with per-entry valid bits
  wsre_ram #(
    .WIDTH(RULE_W),
    .DEPTH(MAX_RULES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_acc && wr_in_range),
    .waddr_i(waddr),
    .wdata_i(wr_rule),
    .re_i   (ram_re),
    .raddr_i(cnt_q[ADDR_W-1:0]),
    .rdata_o(rule)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_acc && wr_in_range) begin
        vld_q[waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= vld_q[cnt_q[ADDR_W-1:0]];
      end
    end
  end

  // evaluate operands
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      wd_q  <= req_i.weekday;
      min_q <= req_i.minute_of_day;
    end
  end

  // window tests on the fetched rule
  assign min_ext   = DIV_W'(min_q);
  assign start_ext = DIV_W'(rule.start_min);
  assign end_ext   = DIV_W'(rule.end_min);

  always_comb begin
    if (rule.start_min == rule.end_min) begin
      in_win  = 1'b1;
      win_len = DAY_MINUTES;
    end else if (rule.start_min < rule.end_min) begin
      in_win  = (min_q >= rule.start_min) && (min_q < rule.end_min);
      win_len = end_ext - start_ext;
    end else begin
      in_win  = (min_q >= rule.start_min) || (min_q < rule.end_min);
      win_len = DAY_MINUTES - start_ext + end_ext;
    end
  end

  assign day_ok    = (wd_q != '0) && rule.weekdays[3'(wd_q - 3'd1)];
  assign pre_match = vld_rd_q && rule.enabled && day_ok && in_win;
  assign slice_pos = ((min_q < rule.start_min) ? (min_ext + DAY_MINUTES) : min_ext) - start_ext;

  // shared bit-serial divider
  wsre_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .sts_o     (div_sts),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      res_act_q <= 1'b0;
      res_cv_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_act_q <= res_act_d;
      res_cv_q  <= res_cv_d;
    end
  end

  // next state and control
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_act_d    = res_act_q;
    res_cv_d     = res_cv_q;
    req_i.ready  = 1'b0;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    div_dividend = win_len;
    div_divisor  = DIV_W'(rule.intervals);
    rsp_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && (req_i.command == CMD_EVAL)) begin
          cnt_d     = '0;
          res_act_d = 1'b0;
          if (req_i.year < min_year_q) begin
            res_cv_d = 1'b0;
            state_d  = ST_DONE;
          end else begin
            res_cv_d = 1'b1;
            state_d  = (lim == '0) ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        ram_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (pre_match && !rule.interval_mode) begin
          res_act_d = 1'b1;
          state_d   = ST_DONE;
        end else if (pre_match && (rule.intervals != '0)) begin
          div_start = 1'b1;
          state_d   = ST_DIV_LEN;
        end else begin
          cnt_d   = cnt_nxt;
          state_d = (cnt_nxt == lim) ? ST_DONE : ST_FETCH;
        end
      end
      ST_DIV_LEN: begin
        div_dividend = slice_pos;
        div_divisor  = div_quot;
        if (div_sts.done) begin
          if (div_quot != '0) begin
            div_start = 1'b1;
            state_d   = ST_DIV_POS;
          end else begin
            cnt_d   = cnt_nxt;
            state_d = (cnt_nxt == lim) ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_DIV_POS: begin
        if (div_sts.done) begin
          if (div_rem < DIV_W'(rule.duration)) begin
            res_act_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            cnt_d   = cnt_nxt;
            state_d = (cnt_nxt == lim) ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_act_q <= res_act_q;
      rsp_cv_q  <= res_cv_q;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.active      = rsp_act_q;
  assign rsp_o.clock_valid = rsp_cv_q;

endmodule

// ----- src/wsre_checker.sv -----
`include "weekly_schedule_rule_evaluator_unit_assert.svh"

module wsre_checker import wsre_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_command_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_active_i,
  input logic rsp_clock_valid_i
);

  // an untrusted clock never switches on
  `WSRE_ASSERT_IMP(a_invalid_clock_off, rsp_valid_i && !rsp_clock_valid_i, !rsp_active_i, "active with invalid clock")

  // an evaluate holds off the next request
  `WSRE_ASSERT_NXT(a_eval_busy, req_valid_i && req_ready_i && (req_command_i == CMD_EVAL), !req_ready_i, "request taken during evaluate")

  // no result appears in the cycle after a request is taken
  `WSRE_ASSERT_NXT(a_no_instant_rsp, req_valid_i && req_ready_i, !$rose(rsp_valid_i), "result too early")

  // a waiting result stays offered
  `WSRE_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result dropped")

endmodule

bind weekly_schedule_rule_evaluator_unit wsre_checker u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_command_i    (req_i.command),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_active_i     (rsp_o.active),
  .rsp_clock_valid_i(rsp_o.clock_valid)
);
